>>> hw/rtl/sbnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnp_pkg
// Shared types and constants of the scene bytecode nesting parser.
// ----------------------------------------------------------------------------
package sbnp_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 64;

  localparam logic [15:0] MAT_COUNT_RESET = 16'hFFFF;

  // Opcodes
  localparam logic [15:0] OP_TERMINATE = 16'h0000;
  localparam logic [15:0] OP_OPEN      = 16'h0001;
  localparam logic [15:0] OP_CLOSE     = 16'h0002;
  localparam logic [15:0] OP_JOINT     = 16'h0010;
  localparam logic [15:0] OP_MATERIAL  = 16'h0011;
  localparam logic [15:0] OP_SHAPE     = 16'h0012;

  // Result kinds
  localparam logic [1:0] KIND_LINK    = 2'd0;
  localparam logic [1:0] KIND_DISPLAY = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_BAD_OP    = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [1:0] ERR_MATERIAL  = 2'd3;

  typedef enum logic [2:0] {
    CMD_TERM,
    CMD_OPEN,
    CMD_CLOSE,
    CMD_JOINT,
    CMD_MAT,
    CMD_SHAPE,
    CMD_BAD
  } cmd_class_t;

  typedef struct packed {
    cmd_class_t  cls;
    logic [15:0] idx;
  } cmd_t;

  // Head of the command queue as seen by the execute side
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] joint_index;
    logic [15:0] parent_index;
    logic [15:0] material_index;
    logic [15:0] shape_index;
    logic [1:0]  error_code;
  } result_t;

  function automatic cmd_class_t classify(input logic [15:0] op);
    cmd_class_t cls;
    unique case (op)
      OP_TERMINATE: cls = CMD_TERM;
      OP_OPEN:      cls = CMD_OPEN;
      OP_CLOSE:     cls = CMD_CLOSE;
      OP_JOINT:     cls = CMD_JOINT;
      OP_MATERIAL:  cls = CMD_MAT;
      OP_SHAPE:     cls = CMD_SHAPE;
      default:      cls = CMD_BAD;
    endcase
    return cls;
  endfunction

endpackage

>>> hw/rtl/sbnp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbnp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/sbnp_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnp_stack
// LIFO with the top entry in a register and the rest in RAM; the entry
// under the top is prefetched every cycle so pushes and pops run back to back.
// ----------------------------------------------------------------------------
module sbnp_stack #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned LW    = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             push,
  input  logic             pop,
  input  logic [WIDTH-1:0] push_data,
  output logic [WIDTH-1:0] top,
  output logic [LW-1:0]    level
);

  logic [LW-1:0]    level_r;
  logic [LW-1:0]    level_nxt;
  logic [WIDTH-1:0] top_r;
  logic [WIDTH-1:0] top_nxt;
  logic             byp_r;
  logic [WIDTH-1:0] byp_data_r;
  logic [WIDTH-1:0] ram_rdata;
  logic [WIDTH-1:0] below;
  logic [LW-1:0]    lvl_m1;
  logic [LW-1:0]    rd_lvl;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             we;

  assign lvl_m1 = level_r - LW'(1);
  assign waddr  = lvl_m1[AW-1:0];
  // Spill the old top into RAM on a push over a non-empty stack
  assign we     = push && (level_r != '0);

  // Entry under the top after this edge
  assign rd_lvl = level_nxt - LW'(2);
  assign raddr  = rd_lvl[AW-1:0];

  assign below = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    level_nxt = level_r;
    top_nxt   = top_r;
    if (clr) begin
      level_nxt = '0;
    end else if (push) begin
      level_nxt = level_r + LW'(1);
      top_nxt   = push_data;
    end else if (pop) begin
      level_nxt = lvl_m1;
      top_nxt   = below;
    end
  end

  sbnp_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      level_r <= level_nxt;
      byp_r   <= we && (waddr == raddr);
    end
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

  assign top   = top_r;
  assign level = level_r;

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(DEPTH))
    else $error("stack level beyond depth");

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && pop))
    else $error("stack push and pop together");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r != LW'(DEPTH)))
    else $error("stack push when full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("stack pop when empty");

endmodule

>>> hw/rtl/sbnp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnp_front
// Accepts commands, classifies the opcode and queues them (two entries).
// ----------------------------------------------------------------------------
module sbnp_front
  import sbnp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] op_code,
  input  logic [15:0] item_index,
  output cmd_head_t   head,
  input  logic        head_pop
);

  cmd_t       q_r [2];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] cnt_r;
  logic       wr;
  logic       rd;

  assign full = (cnt_r == 2'd2);
  assign wr   = push && !full;
  assign rd   = head_pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (wr) begin
        wptr_r <= !wptr_r;
      end
      if (rd) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) begin
      q_r[wptr_r] <= '{cls: classify(op_code), idx: item_index};
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.cmd   = q_r[rptr_r];

endmodule

>>> hw/rtl/sbnp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbnp_back
// Executes queued commands against the nesting state and queues results.
// ----------------------------------------------------------------------------
module sbnp_back
  import sbnp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  cmd_head_t   head,
  output logic        head_pop,
  input  logic        pop,
  output logic        empty,
  output result_t     res
);

  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  logic [15:0] mat_count_r;
  logic        lwj_r, lwj_nxt;
  logic [15:0] cj_r, cj_nxt;
  logic [15:0] cm_r, cm_nxt;

  logic          nest_push, nest_pop, jnt_push, jnt_pop, clr;
  logic [0:0]    nest_top;
  logic [LW-1:0] nest_level;
  logic [15:0]   jnt_top;
  logic [LW-1:0] jnt_level;

  logic    res_vld;
  result_t res_nxt;

  result_t    oq_r [2];
  logic       owptr_r;
  logic       orptr_r;
  logic [1:0] ocnt_r;
  logic       go;
  logic       owr;
  logic       ord;

  assign go       = head.valid && (ocnt_r != 2'd2);
  assign head_pop = go;

  always_comb begin
    lwj_nxt   = lwj_r;
    cj_nxt    = cj_r;
    cm_nxt    = cm_r;
    nest_push = 1'b0;
    nest_pop  = 1'b0;
    jnt_push  = 1'b0;
    jnt_pop   = 1'b0;
    clr       = 1'b0;
    res_vld   = 1'b0;
    res_nxt   = '0;
    if (go) begin
      unique case (head.cmd.cls)
        CMD_TERM: begin
          clr          = 1'b1;
          lwj_nxt      = 1'b0;
          cj_nxt       = '0;
          cm_nxt       = '0;
          res_vld      = 1'b1;
          res_nxt.kind = KIND_END;
        end
        CMD_OPEN: begin
          if (nest_level == LW'(STACK_DEPTH)) begin
            res_vld            = 1'b1;
            res_nxt.kind       = KIND_ERROR;
            res_nxt.error_code = ERR_OVERFLOW;
          end else begin
            nest_push = 1'b1;
            jnt_push  = lwj_r && (jnt_level != LW'(STACK_DEPTH));
          end
        end
        CMD_CLOSE: begin
          if (nest_level == '0) begin
            res_vld            = 1'b1;
            res_nxt.kind       = KIND_ERROR;
            res_nxt.error_code = ERR_UNDERFLOW;
          end else begin
            nest_pop = 1'b1;
            jnt_pop  = nest_top[0] && (jnt_level != '0);
          end
        end
        CMD_JOINT: begin
          cj_nxt  = head.cmd.idx;
          lwj_nxt = 1'b1;
          if (jnt_level != '0) begin
            res_vld              = 1'b1;
            res_nxt.kind         = KIND_LINK;
            res_nxt.joint_index  = head.cmd.idx;
            res_nxt.parent_index = jnt_top;
          end
        end
        CMD_MAT: begin
          cm_nxt  = head.cmd.idx;
          lwj_nxt = 1'b0;
        end
        CMD_SHAPE: begin
          res_vld = 1'b1;
          if (cm_r >= mat_count_r) begin
            res_nxt.kind       = KIND_ERROR;
            res_nxt.error_code = ERR_MATERIAL;
          end else begin
            lwj_nxt                = 1'b0;
            res_nxt.kind           = KIND_DISPLAY;
            res_nxt.joint_index    = cj_r;
            res_nxt.material_index = cm_r;
            res_nxt.shape_index    = head.cmd.idx;
          end
        end
        default: begin
          res_vld            = 1'b1;
          res_nxt.kind       = KIND_ERROR;
          res_nxt.error_code = ERR_BAD_OP;
        end
      endcase
    end
  end

  sbnp_stack #(
    .WIDTH (1),
    .DEPTH (STACK_DEPTH)
  ) u_nest (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .push      (nest_push),
    .pop       (nest_pop),
    .push_data (lwj_r),
    .top       (nest_top),
    .level     (nest_level)
  );

  sbnp_stack #(
    .WIDTH (16),
    .DEPTH (STACK_DEPTH)
  ) u_joint (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .push      (jnt_push),
    .pop       (jnt_pop),
    .push_data (cj_r),
    .top       (jnt_top),
    .level     (jnt_level)
  );

  assign owr = go && res_vld;
  assign ord = pop && (ocnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_count_r <= MAT_COUNT_RESET;
      lwj_r       <= 1'b0;
      cj_r        <= '0;
      cm_r        <= '0;
      owptr_r     <= 1'b0;
      orptr_r     <= 1'b0;
      ocnt_r      <= 2'd0;
    end else begin
      if (cfg_we) begin
        mat_count_r <= cfg_wdata;
      end
      lwj_r <= lwj_nxt;
      cj_r  <= cj_nxt;
      cm_r  <= cm_nxt;
      if (owr) begin
        owptr_r <= !owptr_r;
      end
      if (ord) begin
        orptr_r <= !orptr_r;
      end
      ocnt_r <= ocnt_r + {1'b0, owr} - {1'b0, ord};
    end
    if (owr) begin
      oq_r[owptr_r] <= res_nxt;
    end
  end

  assign empty = (ocnt_r == 2'd0);
  assign res   = oq_r[orptr_r];

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3)
    else $error("result queue count out of range");

  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (go && head.cmd.cls == CMD_TERM) |=> (nest_level == '0 && jnt_level == '0 && !lwj_r))
    else $error("terminate did not clear nesting state");

  a_joint_le_nest: assert property (@(posedge clk) disable iff (!rst_n)
    jnt_level <= nest_level)
    else $error("more open joints than open brackets");

endmodule

>>> hw/rtl/scene_bytecode_nesting_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_bytecode_nesting_parser_core
// Scene-graph command parser: tracks bracket nesting and open joints and
// emits parent links, display records, end markers and errors.
// ----------------------------------------------------------------------------
// The block takes one command per clock (push while full is low) and gives
// at most one result per command, in command order, on a queue-style output
// (read while empty is low, pop to advance). An accepted command is
// registered at the head of the two-entry command queue, where the execute
// logic resolves it and writes its result into the two-entry result queue.
// Execution holds while the result queue holds two results.
// Both stacks keep their top entry in a register and prefetch the entry
// below it from RAM every cycle, so opens, closes and joints follow each
// other at one per clock while the result queue has room. Open, close and
// material produce no result, except for the error of an open on a full
// stack or a close on an empty one; a joint gives a link only under an open
// joint. Write cfg_wdata (the material count) only while no command is in
// flight.
module scene_bytecode_nesting_parser_core
  import sbnp_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // command request channel
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_op_code,
  input  logic [15:0] in_item_index,
  // result request channel
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_joint_index,
  output logic [15:0] out_parent_index,
  output logic [15:0] out_material_index,
  output logic [15:0] out_shape_index,
  output logic [1:0]  out_error_code,
  // configuration: material count
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  cmd_head_t head;
  logic      head_pop;
  result_t   res;

  // Front: accept, classify and hold up to two commands
  sbnp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .op_code    (in_op_code),
    .item_index (in_item_index),
    .head       (head),
    .head_pop   (head_pop)
  );

  // Back: execute against the nesting state, queue results
  sbnp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .head_pop  (head_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  // Break the result record out onto its ports
  assign out_kind           = res.kind;
  assign out_joint_index    = res.joint_index;
  assign out_parent_index   = res.parent_index;
  assign out_material_index = res.material_index;
  assign out_shape_index    = res.shape_index;
  assign out_error_code     = res.error_code;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scene bytecode nesting parser: drives command
// streams through the push/full side, keeps its own copy of the bracket and
// joint stacks to predict links, display records, end markers and errors,
// and compares every popped result field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import sbnp_pkg::*;

  localparam int unsigned DEPTH        = DEFAULT_STACK_DEPTH;
  // Covers the pipeline and both two-entry queues, with margin.
  localparam int unsigned DRAIN_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [15:0] in_op_code;
  logic [15:0] in_item_index;
  logic        empty;
  logic        pop;
  logic [1:0]  out_kind;
  logic [15:0] out_joint_index;
  logic [15:0] out_parent_index;
  logic [15:0] out_material_index;
  logic [15:0] out_shape_index;
  logic [1:0]  out_error_code;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  scene_bytecode_nesting_parser_core #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_op_code         (in_op_code),
    .in_item_index      (in_item_index),
    .empty              (empty),
    .pop                (pop),
    .out_kind           (out_kind),
    .out_joint_index    (out_joint_index),
    .out_parent_index   (out_parent_index),
    .out_material_index (out_material_index),
    .out_shape_index    (out_shape_index),
    .out_error_code     (out_error_code),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Parser state as the bench sees it
  // --------------------------------------------------------------------------
  logic [15:0] mat_limit;                 // material count register
  bit          seen_joint;                // set by a joint, cleared by material, display or terminate
  logic [15:0] cur_joint;
  logic [15:0] cur_material;
  bit          bracket_was_joint [DEPTH];
  int unsigned bracket_depth;
  logic [15:0] open_joint_ids [DEPTH];
  int unsigned joint_depth;

  result_t     expected_records [$];      // predicted results, oldest first
  int unsigned mismatches;

  // Idling switches, toggled by the random tests to get stretches of full rate.
  bit          tx_idle;
  bit          rx_idle;

  // Return the parser to its post-reset (or post-terminate) state.
  // The material count is not part of this.
  function automatic void clear_scene();
    seen_joint    = 1'b0;
    cur_joint     = '0;
    cur_material  = '0;
    bracket_depth = 0;
    joint_depth   = 0;
  endfunction

  // Advance the parser state by one accepted command and queue the result
  // it causes, if any.
  function automatic void predict_parse(input logic [15:0] op, input logic [15:0] idx);
    result_t rec;
    bit      has_rec;
    rec     = '0;
    has_rec = 1'b0;
    case (op)
      OP_TERMINATE: begin
        clear_scene();
        rec.kind = KIND_END;
        has_rec  = 1'b1;
      end
      OP_OPEN: begin
        if (bracket_depth >= DEPTH) begin
          rec.kind       = KIND_ERROR;
          rec.error_code = ERR_OVERFLOW;
          has_rec        = 1'b1;
        end else begin
          // Remember the open joint only when the bracket follows a joint.
          if (seen_joint && joint_depth < DEPTH) begin
            open_joint_ids[joint_depth] = cur_joint;
            joint_depth++;
          end
          bracket_was_joint[bracket_depth] = seen_joint;
          bracket_depth++;
        end
      end
      OP_CLOSE: begin
        if (bracket_depth == 0) begin
          rec.kind       = KIND_ERROR;
          rec.error_code = ERR_UNDERFLOW;
          has_rec        = 1'b1;
        end else begin
          bracket_depth--;
          if (bracket_was_joint[bracket_depth] && joint_depth > 0) joint_depth--;
        end
      end
      OP_JOINT: begin
        if (joint_depth > 0) begin
          rec.kind         = KIND_LINK;
          rec.joint_index  = idx;
          rec.parent_index = open_joint_ids[joint_depth - 1];
          has_rec          = 1'b1;
        end
        cur_joint  = idx;
        seen_joint = 1'b1;
      end
      OP_MATERIAL: begin
        cur_material = idx;
        seen_joint   = 1'b0;
      end
      OP_SHAPE: begin
        has_rec = 1'b1;
        if (cur_material >= mat_limit) begin
          // Dropped: last-was-joint stays as it was.
          rec.kind       = KIND_ERROR;
          rec.error_code = ERR_MATERIAL;
        end else begin
          seen_joint         = 1'b0;
          rec.kind           = KIND_DISPLAY;
          rec.joint_index    = cur_joint;
          rec.material_index = cur_material;
          rec.shape_index    = idx;
        end
      end
      default: begin
        rec.kind       = KIND_ERROR;
        rec.error_code = ERR_BAD_OP;
        has_rec        = 1'b1;
      end
    endcase
    if (has_rec) expected_records.insert(expected_records.size(), rec);
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, timeout
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_gap(input bit enable);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enable || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random pop pattern and in-order checking
  // --------------------------------------------------------------------------
  initial begin : pop_driver
    int unsigned gap;
    @(posedge clk);
    wait (rst_n === 1'b1);
    forever begin
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      gap = idle_gap(rx_idle);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Outputs are sampled right after the edge, so they still hold the values
  // the block presented at that edge.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_records.size() == 0) begin
        $display("%0t: kind mismatch, expected none, actual %h", $time, out_kind);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        report_field("kind",           16'(want.kind),       16'(out_kind));
        report_field("joint_index",    want.joint_index,     out_joint_index);
        report_field("parent_index",   want.parent_index,    out_parent_index);
        report_field("material_index", want.material_index,  out_material_index);
        report_field("shape_index",    want.shape_index,     out_shape_index);
        report_field("error_code",     16'(want.error_code), 16'(out_error_code));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  // Send one command request. Push stays high after acceptance so that
  // back-to-back requests go out at full rate; settle() drops it.
  task automatic send_command(input logic [15:0] op, input logic [15:0] idx);
    int unsigned gap;
    gap = idle_gap(tx_idle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push          <= 1'b1;
    in_op_code    <= op;
    in_item_index <= idx;
    do @(posedge clk); while (full);
    predict_parse(op, idx);
  endtask

  // Drop push, wait for every predicted result, then let commands that give
  // no result drain out of the pipeline.
  task automatic settle();
    push <= 1'b0;
    while (expected_records.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_material_count(input logic [15:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mat_limit = value;
  endtask

  // Material index near the configured limit: mostly in range, some out of
  // range, some anywhere.
  function automatic logic [15:0] pick_material();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60 && mat_limit != 0) return 16'($urandom_range(0, mat_limit - 1));
    if (r < 90) return 16'($urandom_range(mat_limit, 16'hFFFF));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [15:0] any_index();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Field extremes, every opcode, bracket and joint interplay, a shape with
  // an out-of-range material, close on an empty stack, unknown opcodes and
  // terminate clearing the scene.
  task automatic test_directed();
    send_command(OP_SHAPE,    16'h0000);  // display at reset state
    send_command(OP_JOINT,    16'hFFFF);  // no open joint yet: no link
    send_command(OP_OPEN,     16'hFFFF);  // index ignored, pushes joint FFFF
    send_command(OP_JOINT,    16'h0000);  // link under FFFF
    send_command(OP_OPEN,     16'h0000);
    send_command(OP_MATERIAL, 16'hFFFF);
    send_command(OP_JOINT,    16'h5A5A);  // link under 0000
    send_command(OP_SHAPE,    16'h1234);  // material at the limit: error
    send_command(OP_OPEN,     16'h0000);  // failed shape kept the joint flag
    send_command(OP_JOINT,    16'hA5A5);  // link under 5A5A
    send_command(OP_MATERIAL, 16'hFFFE);
    send_command(OP_SHAPE,    16'hFFFF);  // display, clears joint flag
    send_command(OP_OPEN,     16'h0000);  // bracket without a joint
    send_command(OP_JOINT,    16'h0001);  // still under 5A5A
    send_command(OP_CLOSE,    16'hFFFF);
    send_command(OP_CLOSE,    16'h0000);
    send_command(OP_CLOSE,    16'h0000);
    send_command(OP_CLOSE,    16'h0000);
    send_command(OP_CLOSE,    16'h0000);  // empty stack: underflow
    send_command(16'h0003,    16'h0000);  // unknown opcodes
    send_command(16'hFFFF,    16'hFFFF);
    send_command(16'h8000,    16'h0000);
    send_command(16'h0013,    16'h0000);
    send_command(OP_TERMINATE, 16'hFFFF);
    send_command(OP_SHAPE,    16'h0042);  // state cleared by terminate
    settle();
  endtask

  // Mostly well-formed scenes with random content; brackets steered so the
  // stack stays shallow, with a little noise mixed in.
  task automatic send_random_scene(input int unsigned count);
    int unsigned r;
    bit          do_open;
    for (int unsigned i = 0; i < count; i++) begin
      // Change idling behavior every few dozen requests.
      if (i % 50 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_command(any_index(), any_index());
      end else if (r < 6) begin
        send_command(OP_TERMINATE, any_index());
      end else if (r < 38) begin
        if (bracket_depth == 0)       do_open = ($urandom_range(0, 9) != 0);
        else if (bracket_depth >= 12) do_open = ($urandom_range(0, 3) == 0);
        else                          do_open = ($urandom_range(0, 1) != 0);
        send_command(do_open ? OP_OPEN : OP_CLOSE, any_index());
      end else if (r < 62) begin
        send_command(OP_JOINT, any_index());
      end else if (r < 72) begin
        send_command(OP_MATERIAL, pick_material());
      end else begin
        send_command(OP_SHAPE, any_index());
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Walk the material count through its extremes and a few values between,
  // running a batch of random scenes under each.
  task automatic test_material_limits();
    logic [15:0] limits [7];
    limits = '{MAT_COUNT_RESET, 16'h0000, 16'h0001, any_index(), 16'hFFFE,
               16'($urandom_range(2, 64)), MAT_COUNT_RESET};
    foreach (limits[k]) begin
      set_material_count(limits[k]);
      send_random_scene(145);
    end
    settle();
  endtask

  // Dive to the full stack depth with joints and shapes in between, hit the
  // overflow, climb back out and hit the underflow.
  task automatic test_stack_limits();
    int unsigned r;
    set_material_count(16'($urandom_range(1, 16'hFFFF)));
    repeat (2) begin
      while (bracket_depth < DEPTH) begin
        r = $urandom_range(0, 9);
        if (r < 6)      send_command(OP_OPEN, any_index());
        else if (r < 9) send_command(OP_JOINT, any_index());
        else            send_command(OP_SHAPE, any_index());
      end
      repeat ($urandom_range(1, 3)) send_command(OP_OPEN, any_index());
      while (bracket_depth > 0) begin
        r = $urandom_range(0, 19);
        if (r < 12)      send_command(OP_CLOSE, any_index());
        else if (r < 17) send_command(OP_JOINT, any_index());
        else if (r < 18) send_command(OP_MATERIAL, pick_material());
        else             send_command(OP_SHAPE, any_index());
      end
      send_command(OP_CLOSE, any_index());
      send_command(OP_TERMINATE, any_index());
    end
    settle();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_op_code    = '0;
    in_item_index = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    mismatches    = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    mat_limit     = MAT_COUNT_RESET;
    clear_scene();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_stack_limits();
    test_material_limits();
    settle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
